### sv/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token kinds and keyword table for the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam int PosW  = 32;
	localparam int LineW = 24;
	localparam int LenW  = 16;
	localparam int KindW = 6;

	localparam logic [KindW-1:0] K_DOT    = 6'd5;
	localparam logic [KindW-1:0] K_BANG   = 6'd10;
	localparam logic [KindW-1:0] K_EQ     = 6'd12;
	localparam logic [KindW-1:0] K_LT     = 6'd14;
	localparam logic [KindW-1:0] K_GT     = 6'd16;
	localparam logic [KindW-1:0] K_STRING = 6'd18;
	localparam logic [KindW-1:0] K_NUMBER = 6'd19;
	localparam logic [KindW-1:0] K_IDENT  = 6'd20;
	localparam logic [KindW-1:0] K_KEY0   = 6'd21;
	localparam logic [KindW-1:0] K_EOF    = 6'd37;
	localparam logic [KindW-1:0] K_BAD    = 6'd38;
	localparam logic [KindW-1:0] K_UNTERM = 6'd39;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_COMMENT, M_OPER, M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
	} mode_t;

	// One token slot as produced by the scanner.
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [PosW-1:0]  start;
		logic [LenW-1:0]  len;
		logic [LineW-1:0] line;
	} token_t;

	// Up to three tokens per source byte.
	typedef struct packed {
		logic [1:0] count;
		token_t     t0;
		token_t     t1;
		token_t     t2;
	} group_t;

	function automatic logic [47:0] kw_text(input logic [3:0] i);
		unique case (i)
			4'd0:  kw_text = {24'd0, "dna"};
			4'd1:  kw_text = {8'd0,  "ssalc"};
			4'd2:  kw_text = {16'd0, "esle"};
			4'd3:  kw_text = {8'd0,  "eslaf"};
			4'd4:  kw_text = {16'd0, "cnuf"};
			4'd5:  kw_text = {24'd0, "rof"};
			4'd6:  kw_text = {32'd0, "fi"};
			4'd7:  kw_text = {24'd0, "lin"};
			4'd8:  kw_text = {32'd0, "ro"};
			4'd9:  kw_text = {8'd0,  "tnirp"};
			4'd10: kw_text = "nruter";
			4'd11: kw_text = {8'd0,  "repus"};
			4'd12: kw_text = {16'd0, "siht"};
			4'd13: kw_text = {16'd0, "eurt"};
			4'd14: kw_text = {24'd0, "rav"};
			default: kw_text = {8'd0, "elihw"};
		endcase
	endfunction

	function automatic logic [2:0] kw_len(input logic [3:0] i);
		unique case (i)
			4'd0, 4'd5, 4'd7, 4'd14: kw_len = 3'd3;
			4'd2, 4'd4, 4'd12, 4'd13: kw_len = 3'd4;
			4'd6, 4'd8: kw_len = 3'd2;
			4'd10: kw_len = 3'd6;
			default: kw_len = 3'd5;
		endcase
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		is_dig = (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		is_alp = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
	endfunction

endpackage

### sv/stl_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_scan
// Front end: lexer state machine, one byte per cycle while grp_ready is high, emits a token group.
// ----------------------------------------------------------------------------
module stl_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            ch,
	input  logic                  eot,
	output logic                  grp_valid,
	input  logic                  grp_ready,
	output stl_pkg::group_t       grp
);

	stl_pkg::mode_t                 mode_q;
	logic [stl_pkg::KindW-1:0]      pend_q;
	logic [stl_pkg::PosW-1:0]       pos_q;
	logic [stl_pkg::LineW-1:0]      line_q;
	logic [stl_pkg::PosW-1:0]       start_q;
	logic [stl_pkg::LenW-1:0]       len_q;
	logic [47:0]                    kwb_q;

	stl_pkg::mode_t                 mode_d;
	logic [stl_pkg::KindW-1:0]      pend_d;
	logic [stl_pkg::LineW-1:0]      line_d;
	logic [stl_pkg::PosW-1:0]       start_d;
	logic [stl_pkg::LenW-1:0]       len_d;
	logic [47:0]                    kwb_d;
	stl_pkg::group_t                g;
	logic [stl_pkg::KindW-1:0]      ident_kind;
	logic                           used;
	logic                           fire;
	logic [stl_pkg::LenW-1:0]       len_inc;
	logic [stl_pkg::LineW-1:0]      line_inc;

	assign in_ready = grp_ready;
	assign fire = in_valid && in_ready;
	assign len_inc = (len_q == '1) ? len_q : len_q + 1'b1;

	always_comb begin
		ident_kind = stl_pkg::K_IDENT;
		if (len_q <= 16'd6) begin
			for (int i = 15; i >= 0; i--) begin
				if ((16'(stl_pkg::kw_len(4'(i))) == len_q)
					&& (stl_pkg::kw_text(4'(i)) == kwb_q))
					ident_kind = stl_pkg::K_KEY0 + 6'(i);
			end
		end
	end

	always_comb begin
		logic [stl_pkg::KindW-1:0] k [3];
		logic [stl_pkg::PosW-1:0]  s [3];
		logic [stl_pkg::LenW-1:0]  l [3];
		logic [stl_pkg::LineW-1:0] ln [3];
		logic [1:0]                n;
		logic [stl_pkg::LineW-1:0] cl;
		logic [stl_pkg::LenW-1:0]  cur_len;
		n = 2'd0;
		for (int i = 0; i < 3; i++) begin
			k[i] = '0; s[i] = '0; l[i] = '0; ln[i] = '0;
		end
		mode_d = mode_q; pend_d = pend_q; start_d = start_q; len_d = len_q; kwb_d = kwb_q;
		cl = line_q;
		used = 1'b0;
		line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
		cur_len = len_q;
		if (eot) begin
			unique case (mode_q)
				stl_pkg::M_OPER: begin
					k[0] = pend_q; s[0] = start_q; l[0] = 16'd1; n = 2'd1;
				end
				stl_pkg::M_INT, stl_pkg::M_FRAC: begin
					k[0] = stl_pkg::K_NUMBER; s[0] = start_q; l[0] = len_q; n = 2'd1;
				end
				stl_pkg::M_DOT: begin
					k[0] = stl_pkg::K_NUMBER; s[0] = start_q; l[0] = len_q - 1'b1;
					k[1] = stl_pkg::K_DOT; s[1] = pos_q - 1'b1; l[1] = 16'd1; n = 2'd2;
				end
				stl_pkg::M_IDENT: begin
					k[0] = ident_kind; s[0] = start_q; l[0] = len_q; n = 2'd1;
				end
				stl_pkg::M_STRING: begin
					k[0] = stl_pkg::K_UNTERM; s[0] = start_q; l[0] = len_q; n = 2'd1;
				end
				stl_pkg::M_SLASH: begin
					k[0] = stl_pkg::K_BAD; s[0] = start_q; l[0] = 16'd1; n = 2'd1;
				end
				default: ;
			endcase
			k[n] = stl_pkg::K_EOF; s[n] = pos_q; l[n] = '0; n = n + 1'b1;
			mode_d = stl_pkg::M_IDLE; pend_d = '0; len_d = '0; kwb_d = '0;
		end else begin
			unique case (mode_q)
				stl_pkg::M_COMMENT: begin
					if (ch == 8'h0a) begin cl = line_inc; mode_d = stl_pkg::M_IDLE; end
					used = 1'b1;
				end
				stl_pkg::M_SLASH: begin
					if (ch == 8'h2f) begin mode_d = stl_pkg::M_COMMENT; used = 1'b1; end
					else begin k[0] = stl_pkg::K_BAD; s[0] = start_q; l[0] = 16'd1; n = 2'd1; end
				end
				stl_pkg::M_OPER: begin
					if (ch == 8'h3d) begin
						k[0] = pend_q + 1'b1; s[0] = start_q; l[0] = 16'd2; n = 2'd1;
						mode_d = stl_pkg::M_IDLE; used = 1'b1;
					end else begin
						k[0] = pend_q; s[0] = start_q; l[0] = 16'd1; n = 2'd1;
					end
				end
				stl_pkg::M_STRING: begin
					len_d = len_inc;
					if (ch == 8'h0a) cl = line_inc;
					if (ch == 8'h22) begin
						k[0] = stl_pkg::K_STRING; s[0] = start_q; l[0] = len_inc; n = 2'd1;
						mode_d = stl_pkg::M_IDLE;
					end
					used = 1'b1;
				end
				stl_pkg::M_INT, stl_pkg::M_FRAC: begin
					if (stl_pkg::is_dig(ch)) begin len_d = len_inc; used = 1'b1; end
					else if (ch == 8'h2e && mode_q == stl_pkg::M_INT) begin
						len_d = len_inc; mode_d = stl_pkg::M_DOT; used = 1'b1;
					end else begin
						k[0] = stl_pkg::K_NUMBER; s[0] = start_q; l[0] = len_q; n = 2'd1;
					end
				end
				stl_pkg::M_DOT: begin
					if (stl_pkg::is_dig(ch)) begin
						len_d = len_inc; mode_d = stl_pkg::M_FRAC; used = 1'b1;
					end else begin
						k[0] = stl_pkg::K_NUMBER; s[0] = start_q; l[0] = len_q - 1'b1;
						k[1] = stl_pkg::K_DOT; s[1] = pos_q - 1'b1; l[1] = 16'd1; n = 2'd2;
					end
				end
				stl_pkg::M_IDENT: begin
					if (stl_pkg::is_alp(ch) || stl_pkg::is_dig(ch)) begin
						if (len_q < 16'd6) kwb_d = kwb_q | (48'(ch) << {len_q[2:0], 3'b000});
						len_d = len_inc; used = 1'b1;
					end else begin
						k[0] = ident_kind; s[0] = start_q; l[0] = len_q; n = 2'd1;
					end
				end
				default: ;
			endcase
			// line for tokens emitted before any idle-byte newline
			for (int i = 0; i < 3; i++) ln[i] = cl;
			if (!used) begin
				mode_d = stl_pkg::M_IDLE;
				priority case (1'b1)
					(ch == 8'h20 || ch == 8'h0d || ch == 8'h09): ;
					(ch == 8'h0a): cl = line_inc;
					(ch == 8'h28 || ch == 8'h29 || ch == 8'h7b || ch == 8'h7d || ch == 8'h2c
						|| ch == 8'h2e || ch == 8'h2d || ch == 8'h2b || ch == 8'h3b
						|| ch == 8'h2a): begin
						unique case (ch)
							8'h28: k[n] = 6'd0;
							8'h29: k[n] = 6'd1;
							8'h7b: k[n] = 6'd2;
							8'h7d: k[n] = 6'd3;
							8'h2c: k[n] = 6'd4;
							8'h2e: k[n] = 6'd5;
							8'h2d: k[n] = 6'd6;
							8'h2b: k[n] = 6'd7;
							8'h3b: k[n] = 6'd8;
							default: k[n] = 6'd9;
						endcase
						s[n] = pos_q; l[n] = 16'd1; n = n + 1'b1;
					end
					(ch == 8'h21 || ch == 8'h3d || ch == 8'h3c || ch == 8'h3e): begin
						mode_d = stl_pkg::M_OPER; start_d = pos_q; len_d = 16'd1;
						pend_d = (ch == 8'h21) ? stl_pkg::K_BANG :
							(ch == 8'h3d) ? stl_pkg::K_EQ :
							(ch == 8'h3c) ? stl_pkg::K_LT : stl_pkg::K_GT;
					end
					(ch == 8'h2f): begin
						mode_d = stl_pkg::M_SLASH; start_d = pos_q; len_d = 16'd1;
					end
					(ch == 8'h22): begin
						mode_d = stl_pkg::M_STRING; start_d = pos_q; len_d = 16'd1;
					end
					stl_pkg::is_dig(ch): begin
						mode_d = stl_pkg::M_INT; start_d = pos_q; len_d = 16'd1;
					end
					stl_pkg::is_alp(ch): begin
						mode_d = stl_pkg::M_IDENT; start_d = pos_q; len_d = 16'd1;
						kwb_d = 48'(ch);
					end
					default: begin
						k[n] = stl_pkg::K_BAD; s[n] = pos_q; l[n] = 16'd1; n = n + 1'b1;
					end
				endcase
			end
		end
		if (eot) for (int i = 0; i < 3; i++) ln[i] = line_q;
		line_d = cl;
		g.count = n;
		g.t0 = '{k[0], s[0], l[0], ln[0]};
		g.t1 = '{k[1], s[1], l[1], ln[1]};
		g.t2 = '{k[2], s[2], l[2], ln[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= stl_pkg::M_IDLE;
			pend_q    <= '0;
			pos_q     <= '0;
			line_q    <= stl_pkg::LineW'(1);
			start_q   <= '0;
			len_q     <= '0;
			kwb_q     <= '0;
			grp_valid <= 1'b0;
		end else begin
			if (grp_ready) grp_valid <= fire && (g.count != 2'd0);
			if (fire) begin
				mode_q  <= mode_d;
				pend_q  <= pend_d;
				line_q  <= line_d;
				start_q <= start_d;
				len_q   <= len_d;
				kwb_q   <= kwb_d;
				if (!eot) pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && grp_ready) grp <= g;
	end

	ap_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !eot && mode_q == stl_pkg::M_STRING && len_q == '1 |=> len_q == '1)
		else $error("length did not saturate");
	ap_line_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(line_q))
		else $error("line moved without transaction");
	ap_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eot |=> mode_q == stl_pkg::M_IDLE)
		else $error("mode not idle after end of text");

endmodule

### sv/stl_drain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_drain
// Back end: two-entry group queue, serializes tokens onto the output stream.
// ----------------------------------------------------------------------------
module stl_drain (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            grp_valid,
	output logic            grp_ready,
	input  stl_pkg::group_t grp,
	output logic            out_valid,
	input  logic            out_ready,
	output stl_pkg::token_t out_tok,
	output logic            out_last
);

	stl_pkg::group_t q_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic [1:0]      idx_q;
	logic            push;
	logic            pop;
	stl_pkg::group_t head;

	assign head      = q_q[rp_q];
	assign grp_ready = (cnt_q != 2'd2);
	assign push      = grp_valid && grp_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_last  = (idx_q == head.count - 1'b1);
	assign pop       = out_valid && out_ready && out_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    out_tok = head.t0;
			2'd1:    out_tok = head.t1;
			default: out_tok = head.t2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (out_valid && out_ready) idx_q <= out_last ? 2'd0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= grp;
	end

	ap_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> grp.count != 2'd0)
		else $error("empty group queued");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue overflow");
	ap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q < head.count)
		else $error("index past group");

endmodule

### sv/script_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_unit
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Input stream s_axis: one source byte per transaction in tdata, tuser set
// marks end of text (tdata ignored then). Output stream m_axis: one token
// per transaction; tdata carries kind, start, length and line, tlast marks
// the final token caused by one input byte.
// The scanner takes one byte per cycle while the queue has room and registers
// the token group (0 to 3 tokens) it completes; that group is then written
// into the queue, from which its first token is offered on m_axis.
// A two-group queue feeds the output, one token per cycle while m_axis is ready,
// so sustained rate is one byte per cycle unless a byte yields several tokens.
// When m_axis stalls the queue fills and s_axis_tready falls; nothing is lost.
// Reset puts the scanner idle at offset 0, line 1, with the queue empty.
// ----------------------------------------------------------------------------
module script_token_lexer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // ch
	input  logic        s_axis_tuser,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // token_kind, token_start, token_length, token_line
	output logic        m_axis_tlast
);

	logic            grp_valid;
	logic            grp_ready;
	stl_pkg::group_t grp;
	stl_pkg::token_t tok;

	stl_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.ch        (s_axis_tdata),
		.eot       (s_axis_tuser),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp)
	);

	stl_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tok   (tok),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, tok.line, tok.len, tok.start, tok.kind};

endmodule

### tb/tb_script_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_token_lexer_unit
// Self-checking bench for the streaming token lexer.
// ----------------------------------------------------------------------------
// Source bytes go in on s_axis, tokens come back on m_axis. A scoreboard
// class runs its own scanner model on every accepted byte and queues the
// tokens it should give; every token out is checked against the oldest one.
// Directed text covers each operator, a keyword, strings, numbers, comments
// and bad bytes; then random snippets of well-formed source mixed with noise,
// under several sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb_script_token_lexer_unit;

	typedef struct {
		logic [stl_pkg::KindW-1:0] kind;
		logic [31:0]               start;
		logic [15:0]               len;
		logic [23:0]               line;
		logic                      last;
	} exp_tok_t;

	class token_scoreboard;
		stl_pkg::mode_t            mode;
		logic [stl_pkg::KindW-1:0] pend_op;
		logic [31:0]               pos;
		logic [23:0]               line;
		logic [31:0]               lx_start;
		logic [15:0]               lx_len;
		logic [47:0]               kw_bytes;
		exp_tok_t                  pending_tokens[$];
		exp_tok_t                  step_toks[$];
		int                        errors;
		int                        checked;

		function new();
			mode = stl_pkg::M_IDLE; pend_op = '0; pos = '0; line = 24'd1;
			lx_start = '0; lx_len = '0; kw_bytes = '0; errors = 0; checked = 0;
		endfunction

		function void push_tok(int k, logic [31:0] s, int l);
			exp_tok_t t;
			t.kind = 6'(k); t.start = s; t.len = 16'(l); t.line = line; t.last = 1'b0;
			step_toks.push_back(t);
		endfunction

		function logic [stl_pkg::KindW-1:0] keyword_kind();
			string words[16] = '{"and", "class", "else", "false", "func", "for", "if",
				"nil", "or", "print", "return", "super", "this", "true", "var", "while"};
			logic  same;
			if (lx_len > 6) return stl_pkg::K_IDENT;
			for (int i = 0; i < 16; i++) begin
				same = (words[i].len() == lx_len);
				for (int j = 0; same && j < words[i].len(); j++)
					if (kw_bytes[8*j +: 8] != words[i][j]) same = 1'b0;
				if (same) return stl_pkg::K_KEY0 + 6'(i);
			end
			return stl_pkg::K_IDENT;
		endfunction

		function void open_lexeme(stl_pkg::mode_t m);
			mode = m; lx_start = pos; lx_len = 16'd1;
		endfunction

		function void bump_line();
			if (line != 24'hFFFFFF) line++;
		endfunction

		function void bump_len();
			if (lx_len != 16'hFFFF) lx_len++;
		endfunction

		function void fresh_byte(logic [7:0] c);
			mode = stl_pkg::M_IDLE;
			case (c)
				" ", 8'h0d, 8'h09: ;
				8'h0a: bump_line();
				"(": push_tok(0, pos, 1);
				")": push_tok(1, pos, 1);
				"{": push_tok(2, pos, 1);
				"}": push_tok(3, pos, 1);
				",": push_tok(4, pos, 1);
				".": push_tok(5, pos, 1);
				"-": push_tok(6, pos, 1);
				"+": push_tok(7, pos, 1);
				";": push_tok(8, pos, 1);
				"*": push_tok(9, pos, 1);
				"!": begin open_lexeme(stl_pkg::M_OPER); pend_op = stl_pkg::K_BANG; end
				"=": begin open_lexeme(stl_pkg::M_OPER); pend_op = stl_pkg::K_EQ; end
				"<": begin open_lexeme(stl_pkg::M_OPER); pend_op = stl_pkg::K_LT; end
				">": begin open_lexeme(stl_pkg::M_OPER); pend_op = stl_pkg::K_GT; end
				"/": open_lexeme(stl_pkg::M_SLASH);
				"\"": open_lexeme(stl_pkg::M_STRING);
				default: begin
					if (c >= "0" && c <= "9") open_lexeme(stl_pkg::M_INT);
					else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
						open_lexeme(stl_pkg::M_IDENT); kw_bytes = {40'd0, c};
					end else push_tok(stl_pkg::K_BAD, pos, 1);
				end
			endcase
		endfunction

		function void number_then_dot();
			push_tok(stl_pkg::K_NUMBER, lx_start, lx_len - 16'd1);
			push_tok(stl_pkg::K_DOT, pos - 32'd1, 1);
		endfunction

		function void note_input(logic [7:0] c, logic eot);
			logic used, dig, alp;
			used = 1'b0;
			dig = c >= "0" && c <= "9";
			alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
			step_toks.delete();
			if (eot) begin
				case (mode)
					stl_pkg::M_OPER: push_tok(pend_op, lx_start, 1);
					stl_pkg::M_INT, stl_pkg::M_FRAC: push_tok(stl_pkg::K_NUMBER, lx_start, lx_len);
					stl_pkg::M_DOT: number_then_dot();
					stl_pkg::M_IDENT: push_tok(keyword_kind(), lx_start, lx_len);
					stl_pkg::M_STRING: push_tok(stl_pkg::K_UNTERM, lx_start, lx_len);
					stl_pkg::M_SLASH: push_tok(stl_pkg::K_BAD, lx_start, 1);
					default: ;
				endcase
				push_tok(stl_pkg::K_EOF, pos, 0);
				mode = stl_pkg::M_IDLE; pend_op = '0; lx_len = '0; kw_bytes = '0;
			end else begin
				case (mode)
					stl_pkg::M_COMMENT: begin
						if (c == 8'h0a) begin bump_line(); mode = stl_pkg::M_IDLE; end
						used = 1'b1;
					end
					stl_pkg::M_SLASH:
						if (c == "/") begin mode = stl_pkg::M_COMMENT; used = 1'b1; end
						else push_tok(stl_pkg::K_BAD, lx_start, 1);
					stl_pkg::M_OPER:
						if (c == "=") begin
							push_tok(pend_op + 1, lx_start, 2); mode = stl_pkg::M_IDLE;
							used = 1'b1;
						end else push_tok(pend_op, lx_start, 1);
					stl_pkg::M_STRING: begin
						bump_len();
						if (c == 8'h0a) bump_line();
						if (c == "\"") begin
							push_tok(stl_pkg::K_STRING, lx_start, lx_len); mode = stl_pkg::M_IDLE;
						end
						used = 1'b1;
					end
					stl_pkg::M_INT:
						if (dig) begin bump_len(); used = 1'b1; end
						else if (c == ".") begin bump_len(); mode = stl_pkg::M_DOT; used = 1'b1; end
						else push_tok(stl_pkg::K_NUMBER, lx_start, lx_len);
					stl_pkg::M_DOT:
						if (dig) begin bump_len(); mode = stl_pkg::M_FRAC; used = 1'b1; end
						else number_then_dot();
					stl_pkg::M_FRAC:
						if (dig) begin bump_len(); used = 1'b1; end
						else push_tok(stl_pkg::K_NUMBER, lx_start, lx_len);
					stl_pkg::M_IDENT:
						if (alp || dig) begin
							if (lx_len < 6) kw_bytes[8*lx_len +: 8] = c;
							bump_len(); used = 1'b1;
						end else push_tok(keyword_kind(), lx_start, lx_len);
					default: ;
				endcase
				if (!used) fresh_byte(c);
				pos++;
			end
			if (step_toks.size() > 0) step_toks[$].last = 1'b1;
			foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
		endfunction

		function void check_token(logic [79:0] d, logic tl);
			exp_tok_t e;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token %h", d); errors++; return;
			end
			e = pending_tokens.pop_front();
			checked++;
			if (d[5:0] != e.kind) begin
				$error("token_kind exp %0d got %0d", e.kind, d[5:0]); errors++;
			end
			if (d[37:6] != e.start) begin
				$error("token_start exp %0d got %0d", e.start, d[37:6]); errors++;
			end
			if (d[53:38] != e.len) begin
				$error("token_length exp %0d got %0d", e.len, d[53:38]); errors++;
			end
			if (d[77:54] != e.line) begin
				$error("token_line exp %0d got %0d", e.line, d[77:54]); errors++;
			end
			if (tl != e.last) begin
				$error("last_of_run exp %0d got %0d", e.last, tl); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        m_axis_tlast;

	token_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  idle_cycles;
	int  bytes_sent;
	bit  timed_out;

	script_token_lexer_unit u_top (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= 5000 && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	// tvalid stays up between back-to-back transactions; it drops only while idling
	task automatic send_byte(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= eot;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(c, eot);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_snippet();
		string pieces[24] = '{"and ", "class", "else", "false", "func", "for ", "if",
			"nil", "or", "print", "return", "super", "this", "true", "var", "while",
			"x_9", "12.5", "3.", "\"ab\ncd\"", "// c\n", "!= ", "<=", ">"};
		string punct = "(){},.-+;*!=<>/\" \n\t\r";
		case ($urandom_range(9))
			0: send_byte(8'($urandom_range(255)), 1'b0);
			1, 2: send_byte(punct[$urandom_range(punct.len() - 1)], 1'b0);
			3: send_byte($urandom_range(1) ? 8'("a" + $urandom_range(25))
				: 8'("0" + $urandom_range(9)), 1'b0);
			default: send_text(pieces[$urandom_range(23)]);
		endcase
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_cycles = 0;
		bytes_sent = 0;
		timed_out = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("(){},.-+;*! != = == < <= > >= ");
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("/x 1.a 2.5 \"s\n\" abcdefgh while");
		send_byte(8'h00, 1'b1);
		send_text("// note");
		send_byte(8'hA5, 1'b1);
		send_text("\"open");
		send_byte(8'h5A, 1'b1);
		send_text("7.");
		send_byte(8'h00, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			for (int n = 0; n < 22; n++) begin
				send_snippet();
				if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)), 1'b1);
			end
		end
		send_byte(8'h00, 1'b1);
		s_axis_tvalid <= 1'b0;

		recv_stall_pct = 0;
		while (sb.pending_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d source bytes and %0d tokens over four idling phases.",
			bytes_sent, sb.checked);
		if (sb.errors == 0 && sb.pending_tokens.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### sim.f
sv/stl_pkg.sv
sv/stl_scan.sv
sv/stl_drain.sv
sv/script_token_lexer_unit.sv
tb/tb_script_token_lexer_unit.sv
